@@ rtl/hwst_pkg.sv @@
// Shared types, widths, register codes and reset values for the heading turner.
package hwst_pkg;

    // Fraction bits of the soft-turn factor
    localparam int HWST_FRAC_BITS = 16;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int LEN_W   = 16;
    localparam int THR_W   = 15;
    localparam int SPEED_W = 16;
    localparam int WHEEL_W = 18;
    localparam int MODE_W  = 2;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // APB port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register reset values
    localparam logic [THR_W-1:0]   RST_NO_TURN  = 15'd1430;
    localparam logic [THR_W-1:0]   RST_SOFT_THR = 15'd5720;
    localparam logic [THR_W-1:0]   RST_HARD_THR = 15'd12868;
    localparam logic [SPEED_W-1:0] RST_SPD_CAP  = 16'd2560;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_NO_TURN  = 3'd0,
        REG_SOFT_THR = 3'd1,
        REG_HARD_THR = 3'd2,
        REG_SPD_CAP  = 3'd3,
        REG_DISABLE  = 3'd4
    } t_reg_idx;

    // Turning mode
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE = 2'd0,
        MODE_SOFT = 2'd1,
        MODE_HARD = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } t_state;

    // Configuration register set
    typedef struct packed {
        logic [THR_W-1:0]   no_turn;
        logic [THR_W-1:0]   soft_thr;
        logic [THR_W-1:0]   hard_thr;
        logic [SPEED_W-1:0] spd_cap;
        logic               wheels_disabled;
    } t_cfg;

    // Request to the serial divide/multiply unit
    typedef struct packed {
        logic start;
        logic enable;
    } t_dm_req;

endpackage

@@ rtl/hwst_regs.sv @@
// APB configuration registers of the heading turner.
module hwst_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hwst_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hwst_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hwst_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output hwst_pkg::t_cfg                    o_cfg
);
    import hwst_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Write decode; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.no_turn         <= RST_NO_TURN;
            r_cfg.soft_thr        <= RST_SOFT_THR;
            r_cfg.hard_thr        <= RST_HARD_THR;
            r_cfg.spd_cap         <= RST_SPD_CAP;
            r_cfg.wheels_disabled <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_NO_TURN:  r_cfg.no_turn         <= pwdata[THR_W-1:0];
                REG_SOFT_THR: r_cfg.soft_thr        <= pwdata[THR_W-1:0];
                REG_HARD_THR: r_cfg.hard_thr        <= pwdata[THR_W-1:0];
                REG_SPD_CAP:  r_cfg.spd_cap         <= pwdata[SPEED_W-1:0];
                REG_DISABLE:  r_cfg.wheels_disabled <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_NO_TURN:  prdata = CFG_DATA_W'(r_cfg.no_turn);
            REG_SOFT_THR: prdata = CFG_DATA_W'(r_cfg.soft_thr);
            REG_HARD_THR: prdata = CFG_DATA_W'(r_cfg.hard_thr);
            REG_SPD_CAP:  prdata = CFG_DATA_W'(r_cfg.spd_cap);
            REG_DISABLE:  prdata = CFG_DATA_W'(r_cfg.wheels_disabled);
            default:      prdata = '0;
        endcase
    end

endmodule

@@ rtl/hwst_divmul.sv @@
// Bit-serial restoring divide fused with an MSB-first shift-add multiply.
module hwst_divmul #(
    parameter int FRAC_BITS = hwst_pkg::HWST_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hwst_pkg::t_dm_req                      i_req,
    input  logic [hwst_pkg::THR_W-1:0]             i_num,
    input  logic [hwst_pkg::THR_W-1:0]             i_den,
    input  logic [hwst_pkg::SPEED_W-1:0]           i_base,
    output logic                                   o_done,
    output logic [hwst_pkg::SPEED_W+FRAC_BITS-1:0] o_prod
);
    import hwst_pkg::*;

    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int PROD_W = SPEED_W + FRAC_BITS;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_en;
    logic [THR_W-1:0]   r_rem;
    logic [THR_W-1:0]   r_den;
    logic [SPEED_W-1:0] r_base;
    logic [PROD_W-1:0]  r_acc;

    logic [THR_W:0]     w_shift;
    logic [THR_W:0]     w_diff;
    logic               w_qbit;
    logic [THR_W-1:0]   n_rem;
    logic [PROD_W-1:0]  n_acc;

    // One quotient bit per cycle; each bit folds base into the product at once
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_qbit  = r_en && (w_shift >= {1'b0, r_den});
    assign n_rem   = w_qbit ? w_diff[THR_W-1:0] : w_shift[THR_W-1:0];
    assign n_acc   = {r_acc[PROD_W-2:0], 1'b0} + (w_qbit ? PROD_W'(r_base) : '0);

    assign o_done = r_done;
    assign o_prod = r_acc;

    // Control: count steps, flag completion for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands on start, then step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_en   <= i_req.enable;
            r_rem  <= i_req.enable ? i_num : '0;
            r_den  <= i_den;
            r_base <= i_base;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

endmodule

@@ rtl/heading_to_wheel_speed_turner_top.sv @@
// Top level: stream ports, turn-mode sequencer, wheel speed assembly.
// Each item goes through the sequencer states idle, evaluate and finish in no turn
// and hard turn, with the divide wait between evaluate and finish in soft turn.
// Finish holds while the output is stalled; no new item is taken until idle, and
// the serial divide/multiply unit produces one quotient bit per cycle.
// A finished result sits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the mode to no turn and loads register defaults.
module heading_to_wheel_speed_turner_top #(
    parameter int FACTOR_FRAC_BITS = hwst_pkg::HWST_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hwst_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [hwst_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [hwst_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [15:0] heading_angle (signed), [31:16] heading_length
    input  logic [hwst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [17:0] left_speed, [35:18] right_speed, [37:36] turn_mode, [39:38] zero
    output logic [hwst_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import hwst_pkg::*;

    localparam int PROD_W = SPEED_W + FACTOR_FRAC_BITS;
    localparam int L_LO = 0;
    localparam int R_LO = WHEEL_W;
    localparam int M_LO = 2 * WHEEL_W;

    t_cfg                 w_cfg;
    t_state               r_state, n_state;
    t_mode                r_turn_state, n_mode;
    t_dm_req              w_dm_req;
    logic                 w_dm_done;
    logic [PROD_W-1:0]    w_prod;

    logic [ANGLE_W-1:0]   r_angle;
    logic [LEN_W-1:0]     r_len;
    logic [SPEED_W-1:0]   r_base;
    logic                 r_left_turn;
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic                 w_in_xfer;
    logic                 w_load_out;
    logic [ANGLE_W-1:0]   w_mag;
    logic [ANGLE_W-1:0]   w_hard_ext;
    logic                 w_div_en;
    logic [THR_W-1:0]     w_num;
    logic [SPEED_W-1:0]   w_base;
    logic [SPEED_W-1:0]   w_slow_soft;
    logic                 w_rem_nz;
    logic [WHEEL_W-1:0]   w_slow;
    logic [WHEEL_W-1:0]   w_fast;
    logic [WHEEL_W-1:0]   w_left;
    logic [WHEEL_W-1:0]   w_right;

    hwst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hwst_divmul #(
        .FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_divmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dm_req),
        .i_num   (w_num),
        .i_den   (w_cfg.hard_thr),
        .i_base  (w_base),
        .o_done  (w_dm_done),
        .o_prod  (w_prod)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Angle magnitude; the most negative code maps to 32768
    assign w_mag      = r_angle[ANGLE_W-1] ? ANGLE_W'(-r_angle) : r_angle;
    assign w_hard_ext = ANGLE_W'(w_cfg.hard_thr);
    assign w_div_en   = (w_cfg.hard_thr != '0) && (w_mag <= w_hard_ext);
    assign w_num      = w_hard_ext[THR_W-1:0] - w_mag[THR_W-1:0];
    assign w_base     = (r_len < w_cfg.spd_cap) ? r_len : w_cfg.spd_cap;

    // Mode update with hysteresis: soft turn is entered only from no turn
    always_comb begin
        if (w_mag <= ANGLE_W'(w_cfg.no_turn)) begin
            n_mode = MODE_NONE;
        end else if (w_mag > w_hard_ext) begin
            n_mode = MODE_HARD;
        end else if (r_turn_state == MODE_NONE && w_mag > ANGLE_W'(w_cfg.soft_thr)) begin
            n_mode = MODE_SOFT;
        end else begin
            n_mode = r_turn_state;
        end
    end

    // Sequencer next state and strobes
    always_comb begin
        n_state         = r_state;
        w_dm_req.start  = 1'b0;
        w_dm_req.enable = w_div_en;
        w_load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (n_mode == MODE_SOFT) begin
                    w_dm_req.start = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (w_dm_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Turn mode is kept across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_state <= MODE_NONE;
        end else if (r_state == ST_EVAL) begin
            r_turn_state <= n_mode;
        end
    end

    // Capture the input transfer and the per-item operands
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_angle <= s_axis_tdata[ANGLE_W-1:0];
            r_len   <= s_axis_tdata[ANGLE_W +: LEN_W];
        end
        if (r_state == ST_EVAL) begin
            r_base      <= w_base;
            r_left_turn <= !r_angle[ANGLE_W-1] && (r_angle != '0);
        end
    end

    // Slow wheel is floor(base*f); fast wheel is 2*base minus ceil(base*f)
    assign w_slow_soft = w_prod[FACTOR_FRAC_BITS +: SPEED_W];
    assign w_rem_nz    = |w_prod[FACTOR_FRAC_BITS-1:0];

    always_comb begin
        case (r_turn_state)
            MODE_SOFT: begin
                w_slow = WHEEL_W'(w_slow_soft);
                w_fast = WHEEL_W'({r_base, 1'b0}) - WHEEL_W'(w_slow_soft)
                         - WHEEL_W'(w_rem_nz);
            end
            MODE_HARD: begin
                w_slow = -WHEEL_W'(w_cfg.spd_cap);
                w_fast = WHEEL_W'(w_cfg.spd_cap);
            end
            default: begin
                w_slow = WHEEL_W'(r_base);
                w_fast = WHEEL_W'(r_base);
            end
        endcase
        if (w_cfg.wheels_disabled) begin
            w_left  = '0;
            w_right = '0;
        end else if (r_left_turn) begin
            w_left  = w_slow;
            w_right = w_fast;
        end else begin
            w_left  = w_fast;
            w_right = w_slow;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_data <= {2'b00, r_turn_state, w_right, w_left};
        end
    end

    // Disabled wheels always report zero speed
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && w_cfg.wheels_disabled) |-> (r_m_data[M_LO-1:0] == '0))
        else $error("speed nonzero while wheels disabled");

    // No turn drives both wheels alike
    a_none_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[M_LO +: MODE_W] == MODE_NONE)
        |-> (r_m_data[L_LO +: WHEEL_W] == r_m_data[R_LO +: WHEEL_W]))
        else $error("unequal speeds in no turn");

    // Hard turn spins in place
    a_hard_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[M_LO +: MODE_W] == MODE_HARD)
        |-> (WHEEL_W'(r_m_data[L_LO +: WHEEL_W] + r_m_data[R_LO +: WHEEL_W]) == '0))
        else $error("hard turn speeds not opposite");

    // The divide unit finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dm_done |-> (r_state == ST_DIV))
        else $error("divide done outside wait state");

endmodule
